[rtl/ddo_pkg.sv]
// ddo_pkg: shared types, constants and the arctangent table for the
// differential drive odometry block. No dependencies.
`timescale 1ns / 1ps

package ddo_pkg;

  // cordic setup
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_N     = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int CORDIC_CNT_W = $clog2(CORDIC_N + 1);
  localparam int CW           = 34;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  // datapath widths
  localparam int OPA_W = 77;
  localparam int ACC_W = 109;
  localparam int NUM_W = 101;
  localparam int DEN_W = 50;
  localparam int QUO_W = 64;
  localparam int MAG_W = 47;

  // arithmetic constants
  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  localparam int          DIST_SHIFT = 46;
  localparam int          DIST_QSHIFT = 48;
  // ceil(2^80 / 234375), exact floor division for numerators below 2^62
  localparam logic [63:0] DIST_RECIP    = 64'd5158083497022417813;
  localparam logic [31:0] DIST_RECIP_LO = DIST_RECIP[31:0];
  localparam logic [31:0] DIST_RECIP_HI = DIST_RECIP[63:32];
  localparam logic [31:0] RATE_SCALE = 32'd60000000;

  // input queue depth
  localparam int QDEPTH = 2;

  // configuration register indexes
  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_BASE   = 1'b1;
  localparam logic [19:0] RADIUS_RESET = 20'd30000;
  localparam logic [23:0] BASE_RESET   = 24'd165000;

  // classified item handed from front to back
  typedef struct packed {
    logic [24:0] abs_sum;
    logic        sum_neg;
    logic [24:0] abs_diff;
    logic        diff_neg;
    logic [31:0] dt;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DWAIT,
    ST_UPD,
    ST_QUAT
  } state_e;

  typedef enum logic [3:0] {
    PH_SR,
    PH_SDT,
    PH_SPI,
    PH_RLO,
    PH_RHI,
    PH_DR,
    PH_DDT,
    PH_BASE,
    PH_DX,
    PH_DY
  } phase_e;

  // arctangent of 2^-i in binary angle units
  function automatic logic [31:0] atan_ba(logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

[rtl/ddo_div.sv]
// ddo_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on ddo_pkg for widths.
`timescale 1ns / 1ps

module ddo_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ddo_pkg::NUM_W-1:0]     num_i,
  input  logic [ddo_pkg::DEN_W-1:0]     den_i,
  output logic                          busy_o,
  output logic [ddo_pkg::QUO_W-1:0]     quot_o
);

  localparam int CNT_W = $clog2(ddo_pkg::NUM_W);

  logic                        busy_q, busy_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [ddo_pkg::NUM_W-1:0]   num_q, num_d;
  logic [ddo_pkg::DEN_W-1:0]   den_q, den_d;
  logic [ddo_pkg::DEN_W-1:0]   rem_q, rem_d;
  logic [ddo_pkg::QUO_W-1:0]   quot_q, quot_d;
  logic [ddo_pkg::DEN_W:0]     rem2;
  logic                        ge;

  // one restoring step
  always_comb begin
    rem2   = {rem_q, num_q[ddo_pkg::NUM_W-1]};
    ge     = rem2 >= {1'b0, den_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d  = ge ? ddo_pkg::DEN_W'(rem2 - {1'b0, den_q}) : ddo_pkg::DEN_W'(rem2);
      num_d  = {num_q[ddo_pkg::NUM_W-2:0], 1'b0};
      quot_d = {quot_q[ddo_pkg::QUO_W-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ddo_pkg::NUM_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

[rtl/ddo_cordic.sv]
// ddo_cordic: iterative rotation-mode cordic giving cos and sin in Q30,
// one micro-rotation per cycle. Depends on ddo_pkg.
`timescale 1ns / 1ps

module ddo_cordic (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [31:0]                     angle_i,
  output logic                            busy_o,
  output logic signed [ddo_pkg::CW-1:0]   cos_o,
  output logic signed [ddo_pkg::CW-1:0]   sin_o
);

  logic                                 busy_q, busy_d;
  logic [ddo_pkg::CORDIC_CNT_W-1:0]     cnt_q, cnt_d;
  logic                                 flip_q, flip_d;
  logic signed [ddo_pkg::CW-1:0]        x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [ddo_pkg::CW-1:0]        xs, ys, at;
  logic [31:0]                          quarter, turned;

  // start folds the left half plane, then one rotation per cycle
  always_comb begin
    quarter = angle_i + 32'h4000_0000;
    turned  = quarter[31] ? angle_i + 32'h8000_0000 : angle_i;
    xs      = x_q >>> cnt_q;
    ys      = y_q >>> cnt_q;
    at      = $signed({2'b00, ddo_pkg::atan_ba(5'(cnt_q))});
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    flip_d  = flip_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      flip_d = quarter[31];
      x_d    = ddo_pkg::CORDIC_X0;
      y_d    = '0;
      z_d    = $signed({{2{turned[31]}}, turned});
    end else if (busy_q) begin
      if (!z_q[ddo_pkg::CW-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ddo_pkg::CORDIC_CNT_W'(ddo_pkg::CORDIC_N - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // vector registers
  always_ff @(posedge clk_i) begin
    flip_q <= flip_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign busy_o = busy_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

[rtl/ddo_queue.sv]
// ddo_queue: short register queue of classified items between front and back.
// Depends on ddo_pkg for the item type and depth.
`timescale 1ns / 1ps

module ddo_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ddo_pkg::job_t     data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output ddo_pkg::job_t     data_o
);

  localparam int PTR_W = (ddo_pkg::QDEPTH > 1) ? $clog2(ddo_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(ddo_pkg::QDEPTH + 1);

  ddo_pkg::job_t     mem_q [ddo_pkg::QDEPTH];
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  // pointer and fill count update
  always_comb begin
    do_push = push_i && !full_o;
    do_pop  = pop_i && !empty_o;
    wp_d    = wp_q;
    rp_d    = rp_q;
    cnt_d   = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PTR_W'(ddo_pkg::QDEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (rp_q == PTR_W'(ddo_pkg::QDEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  assign full_o  = cnt_q == CNT_W'(ddo_pkg::QDEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];

endmodule

[rtl/ddo_front.sv]
// ddo_front: takes wheel speed items, measures elapsed time against the
// last stamp and forms wheel sum and difference. Depends on ddo_pkg.
`timescale 1ns / 1ps

module ddo_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  logic signed [23:0]  left_rpm_i,
  input  logic signed [23:0]  right_rpm_i,
  input  logic [31:0]         stamp_us_i,
  output logic                q_push_o,
  output ddo_pkg::job_t       job_o
);

  logic [31:0]         last_stamp_q;
  logic signed [24:0]  sum, diff;
  logic                take;

  // classify the item
  always_comb begin
    take           = push_i && !full_i;
    sum            = 25'(left_rpm_i) + 25'(right_rpm_i);
    diff           = 25'(right_rpm_i) - 25'(left_rpm_i);
    job_o.sum_neg  = sum[24];
    job_o.abs_sum  = sum[24] ? 25'(-sum) : 25'(sum);
    job_o.diff_neg = diff[24];
    job_o.abs_diff = diff[24] ? 25'(-diff) : 25'(diff);
    job_o.dt       = stamp_us_i - last_stamp_q;
  end

  // last stamp follows every transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_stamp_q <= '0;
    end else if (take) begin
      last_stamp_q <= stamp_us_i;
    end
  end

  assign q_push_o = take;

endmodule

[rtl/ddo_back.sv]
// ddo_back: sequencer that scales speeds, divides, resolves motion along
// the heading and forms the result. Depends on ddo_pkg, ddo_div, ddo_cordic.
`timescale 1ns / 1ps

module ddo_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [23:0]         cfg_data_i,
  input  logic                q_empty_i,
  input  ddo_pkg::job_t       q_job_i,
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic signed [39:0]  pos_x_um_o,
  output logic signed [39:0]  pos_y_um_o,
  output logic [31:0]         heading_angle_o,
  output logic signed [15:0]  quat_z_o,
  output logic signed [15:0]  quat_w_o
);

  localparam int OPA_W = ddo_pkg::OPA_W;
  localparam int ACC_W = ddo_pkg::ACC_W;
  localparam int MAG_W = ddo_pkg::MAG_W;

  function automatic logic signed [48:0] sdelta(logic [MAG_W-1:0] mag, logic neg);
    logic signed [48:0] m;
    m = $signed({2'b00, mag});
    return neg ? -m : m;
  endfunction

  function automatic logic signed [39:0] sat_pos(logic signed [48:0] v);
    logic signed [39:0] r;
    if (v > 49'sd549755813887) begin
      r = 40'sd549755813887;
    end else if (v < -49'sd549755813888) begin
      r = -40'sd549755813888;
    end else begin
      r = 40'(v);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] to_q15(logic signed [ddo_pkg::CW-1:0] v);
    logic signed [ddo_pkg::CW:0] t;
    logic signed [19:0]          r;
    logic signed [15:0]          o;
    t = (ddo_pkg::CW+1)'(v) + 35'sd16384;
    r = 20'(t >>> 15);
    if (r > 20'sd32767) begin
      o = 16'sd32767;
    end else if (r < -20'sd32767) begin
      o = -16'sd32767;
    end else begin
      o = 16'(r);
    end
    return o;
  endfunction

  ddo_pkg::state_e     state_q, state_d;
  ddo_pkg::phase_e     phase_q, phase_d;
  ddo_pkg::job_t       job_q, job_d;
  logic [19:0]         radius_q;
  logic [23:0]         base_q;
  logic [OPA_W-1:0]    opa_q, opa_d, m_q, m_d;
  logic [31:0]         opb_q, opb_d;
  logic [1:0]          k_q, k_d, lim_q, lim_d;
  logic [ACC_W-1:0]    acc_q, acc_d, mac;
  logic [31:0]         chunk;
  logic [63:0]         prod;
  logic [MAG_W-1:0]    travel_q, travel_d;
  logic [MAG_W-1:0]    dx_q, dx_d, dy_q, dy_d;
  logic signed [39:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [31:0]         heading_q, heading_d, dth;
  logic                out_valid_q, out_valid_d;
  logic signed [39:0]  out_x_q, out_y_q;
  logic [31:0]         out_h_q;
  logic signed [15:0]  out_qz_q, out_qw_q;
  logic                out_we;

  logic                          div2_start, div2_busy;
  logic [ddo_pkg::NUM_W-1:0]     div2_num;
  logic [ddo_pkg::DEN_W-1:0]     div2_den;
  logic [ddo_pkg::QUO_W-1:0]     div2_quot;
  logic                          cor_start, cor_busy;
  logic [31:0]                   cor_angle;
  logic signed [ddo_pkg::CW-1:0] cor_cos, cor_sin, cos_abs, sin_abs;
  logic                          cos_neg, sin_neg;

  // heading divider, and the cordic for heading and quaternion
  ddo_div u_div_turn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div2_start),
    .num_i   (div2_num),
    .den_i   (div2_den),
    .busy_o  (div2_busy),
    .quot_o  (div2_quot)
  );

  ddo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .busy_o  (cor_busy),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  // chunked multiply-accumulate, 32 bits of the wide operand per cycle
  always_comb begin
    unique case (k_q)
      2'd0:    chunk = opa_q[31:0];
      2'd1:    chunk = opa_q[63:32];
      default: chunk = {19'b0, opa_q[OPA_W-1:64]};
    endcase
    prod = 64'(chunk) * 64'(opb_q);
    mac  = acc_q + (ACC_W'(prod) << {k_q, 5'b0});
  end

  // signs and magnitudes of the rotation, and the heading increment
  always_comb begin
    cos_neg = cor_cos[ddo_pkg::CW-1];
    sin_neg = cor_sin[ddo_pkg::CW-1];
    cos_abs = cos_neg ? -cor_cos : cor_cos;
    sin_abs = sin_neg ? -cor_sin : cor_sin;
    if (base_q == '0) begin
      dth = '0;
    end else begin
      dth = job_q.diff_neg ? -div2_quot[31:0] : div2_quot[31:0];
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    job_d      = job_q;
    opa_d      = opa_q;
    opb_d      = opb_q;
    k_d        = k_q;
    lim_d      = lim_q;
    acc_d      = acc_q;
    m_d        = m_q;
    travel_d   = travel_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    heading_d  = heading_q;
    q_pop_o    = 1'b0;
    cor_start  = 1'b0;
    cor_angle  = heading_q;
    div2_start = 1'b0;
    div2_num   = {m_q, 24'b0};
    div2_den   = ddo_pkg::DEN_W'(mac);
    out_we     = 1'b0;
    unique case (state_q)
      ddo_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          job_d     = q_job_i;
          opa_d     = OPA_W'(q_job_i.abs_sum);
          opb_d     = 32'(radius_q);
          k_d       = '0;
          lim_d     = 2'd0;
          acc_d     = '0;
          phase_d   = ddo_pkg::PH_SR;
          state_d   = ddo_pkg::ST_MUL;
          cor_start = 1'b1;
        end
      end
      ddo_pkg::ST_MUL: begin
        acc_d = mac;
        k_d   = k_q + 1'b1;
        if (k_q == lim_q) begin
          acc_d = '0;
          k_d   = '0;
          unique case (phase_q)
            ddo_pkg::PH_SR: begin
              opa_d   = OPA_W'(mac);
              opb_d   = job_q.dt;
              lim_d   = 2'd1;
              phase_d = ddo_pkg::PH_SDT;
            end
            ddo_pkg::PH_SDT: begin
              opa_d   = OPA_W'(mac);
              opb_d   = ddo_pkg::PI_Q30;
              lim_d   = 2'd2;
              phase_d = ddo_pkg::PH_SPI;
            end
            ddo_pkg::PH_SPI: begin
              // distance divide by reciprocal, low half of the constant first
              opa_d   = OPA_W'(mac >> ddo_pkg::DIST_SHIFT);
              opb_d   = ddo_pkg::DIST_RECIP_LO;
              lim_d   = 2'd1;
              phase_d = ddo_pkg::PH_RLO;
            end
            ddo_pkg::PH_RLO: begin
              // carry the upper part of the low product into the high half
              acc_d   = mac >> 32;
              opb_d   = ddo_pkg::DIST_RECIP_HI;
              lim_d   = 2'd1;
              phase_d = ddo_pkg::PH_RHI;
            end
            ddo_pkg::PH_RHI: begin
              travel_d = mac[ddo_pkg::DIST_QSHIFT+MAG_W-1:ddo_pkg::DIST_QSHIFT];
              opa_d    = OPA_W'(job_q.abs_diff);
              opb_d    = 32'(radius_q);
              lim_d    = 2'd0;
              phase_d  = ddo_pkg::PH_DR;
            end
            ddo_pkg::PH_DR: begin
              opa_d   = OPA_W'(mac);
              opb_d   = job_q.dt;
              lim_d   = 2'd1;
              phase_d = ddo_pkg::PH_DDT;
            end
            ddo_pkg::PH_DDT: begin
              m_d     = OPA_W'(mac);
              opa_d   = OPA_W'(base_q);
              opb_d   = ddo_pkg::RATE_SCALE;
              lim_d   = 2'd0;
              phase_d = ddo_pkg::PH_BASE;
            end
            ddo_pkg::PH_BASE: begin
              // no turn at all with a zero wheel base
              div2_start = base_q != '0;
              state_d    = ddo_pkg::ST_DWAIT;
            end
            ddo_pkg::PH_DX: begin
              dx_d    = mac[MAG_W+29:30];
              opb_d   = sin_abs[31:0];
              lim_d   = 2'd1;
              phase_d = ddo_pkg::PH_DY;
            end
            ddo_pkg::PH_DY: begin
              dy_d    = mac[MAG_W+29:30];
              state_d = ddo_pkg::ST_UPD;
            end
            default: begin
              state_d = ddo_pkg::ST_IDLE;
            end
          endcase
        end
      end
      ddo_pkg::ST_DWAIT: begin
        if (!div2_busy && !cor_busy) begin
          opa_d   = OPA_W'(travel_q);
          opb_d   = cos_abs[31:0];
          k_d     = '0;
          lim_d   = 2'd1;
          acc_d   = '0;
          phase_d = ddo_pkg::PH_DX;
          state_d = ddo_pkg::ST_MUL;
        end
      end
      ddo_pkg::ST_UPD: begin
        pos_x_d   = sat_pos(49'(pos_x_q) + sdelta(dx_q, job_q.sum_neg ^ cos_neg));
        pos_y_d   = sat_pos(49'(pos_y_q) + sdelta(dy_q, job_q.sum_neg ^ sin_neg));
        heading_d = heading_q + dth;
        cor_start = 1'b1;
        cor_angle = heading_d >> 1;
        state_d   = ddo_pkg::ST_QUAT;
      end
      ddo_pkg::ST_QUAT: begin
        if (!cor_busy && (!out_valid_q || pop_i)) begin
          out_we  = 1'b1;
          state_d = ddo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ddo_pkg::ST_IDLE;
      end
    endcase
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (out_we) begin
      out_valid_d = 1'b1;
    end
  end

  // control, odometry state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ddo_pkg::ST_IDLE;
      phase_q     <= ddo_pkg::PH_SR;
      k_q         <= '0;
      lim_q       <= '0;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
      radius_q    <= ddo_pkg::RADIUS_RESET;
      base_q      <= ddo_pkg::BASE_RESET;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      k_q         <= k_d;
      lim_q       <= lim_d;
      out_valid_q <= out_valid_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      heading_q   <= heading_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ddo_pkg::CFG_RADIUS: radius_q <= cfg_data_i[19:0];
          ddo_pkg::CFG_BASE:   base_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    opa_q    <= opa_d;
    opb_q    <= opb_d;
    acc_q    <= acc_d;
    m_q      <= m_d;
    travel_q <= travel_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    if (out_we) begin
      out_x_q  <= pos_x_q;
      out_y_q  <= pos_y_q;
      out_h_q  <= heading_q;
      out_qz_q <= to_q15(cor_sin);
      out_qw_q <= to_q15(cor_cos);
    end
  end

  assign empty_o         = !out_valid_q;
  assign pos_x_um_o      = out_x_q;
  assign pos_y_um_o      = out_y_q;
  assign heading_angle_o = out_h_q;
  assign quat_z_o        = out_qz_q;
  assign quat_w_o        = out_qw_q;

endmodule

[rtl/diff_drive_wheel_odometry.sv]
// diff_drive_wheel_odometry: top level, front classifier, item queue and
// odometry back end. Depends on ddo_pkg, ddo_front, ddo_queue, ddo_back.
//
// channel   direction  handshake              payload
// input     in         push / full            left_rpm_i, right_rpm_i, stamp_us_i
// result    out        empty / pop            pos_x_um_o, pos_y_um_o, heading_angle_o,
//                                             quat_z_o, quat_w_o
// config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// an item in the back end runs chunked multiplies and control, waits on the
// 101-step serial divider for the heading increment and then on the quaternion
// cordic; a zero wheel base skips the divider.
// the front takes an item every cycle until the two-entry queue is full.
// a finished result waits in the output register while the next item runs;
// the back end stalls at its end until that register is read.
// reset clears pose, last stamp and the queue and loads the default geometry.
`timescale 1ns / 1ps

module diff_drive_wheel_odometry (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [23:0]         cfg_data_i,
  input  logic                push,
  output logic                full,
  input  logic signed [23:0]  left_rpm_i,
  input  logic signed [23:0]  right_rpm_i,
  input  logic [31:0]         stamp_us_i,
  output logic                empty,
  input  logic                pop,
  output logic signed [39:0]  pos_x_um_o,
  output logic signed [39:0]  pos_y_um_o,
  output logic [31:0]         heading_angle_o,
  output logic signed [15:0]  quat_z_o,
  output logic signed [15:0]  quat_w_o
);

  logic           q_push, q_pop, q_empty;
  ddo_pkg::job_t  push_job, pop_job;

  // classify incoming transfers
  ddo_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .left_rpm_i  (left_rpm_i),
    .right_rpm_i (right_rpm_i),
    .stamp_us_i  (stamp_us_i),
    .q_push_o    (q_push),
    .job_o       (push_job)
  );

  // decoupling queue
  ddo_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (pop_job)
  );

  // odometry engine
  ddo_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .q_empty_i       (q_empty),
    .q_job_i         (pop_job),
    .q_pop_o         (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .pos_x_um_o      (pos_x_um_o),
    .pos_y_um_o      (pos_y_um_o),
    .heading_angle_o (heading_angle_o),
    .quat_z_o        (quat_z_o),
    .quat_w_o        (quat_w_o)
  );

endmodule

[tb/diff_drive_wheel_odometry_test.sv]
// diff_drive_wheel_odometry_test: self-checking bench for the wheel odometry block.
// Holds its own pose predictor and drives random traffic on both queue ports.
// Depends on ddo_pkg and diff_drive_wheel_odometry.
`timescale 1ns / 1ps

module diff_drive_wheel_odometry_test;

  typedef struct {
    logic signed [23:0] left_rpm;
    logic signed [23:0] right_rpm;
    logic [31:0]        stamp_us;
  } wheel_sample_t;

  typedef struct {
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic [31:0]        heading;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } pose_t;

  localparam longint POS_HI = 64'sd549755813887;
  localparam longint POS_LO = -64'sd549755813888;
  localparam logic [31:0] ATAN_TBL [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

  logic clk, rst_n;
  logic cfg_we, cfg_idx;
  logic [23:0] cfg_data;
  logic push, full, empty, pop;
  logic signed [23:0] left_rpm, right_rpm;
  logic [31:0] stamp_us;
  logic signed [39:0] pos_x_o, pos_y_o;
  logic [31:0] heading_o;
  logic signed [15:0] quat_z_o, quat_w_o;

  diff_drive_wheel_odometry u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .push(push), .full(full),
    .left_rpm_i(left_rpm), .right_rpm_i(right_rpm), .stamp_us_i(stamp_us),
    .empty(empty), .pop(pop),
    .pos_x_um_o(pos_x_o), .pos_y_um_o(pos_y_o), .heading_angle_o(heading_o),
    .quat_z_o(quat_z_o), .quat_w_o(quat_w_o)
  );

  // predictor state
  logic [19:0] radius_um;
  logic [23:0] base_um;
  longint      odo_x = 0, odo_y = 0;
  logic [31:0] odo_heading = '0, odo_stamp = '0;

  wheel_sample_t samples_pending[$];
  pose_t         poses_expected[$];
  int  errors = 0, n_sent = 0, n_checked = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // fixed-angle cordic, cos/sin in q30
  function automatic void cordic_sincos(input logic [31:0] ang, output longint c,
                                        output longint s);
    logic        flip;
    logic [31:0] t;
    longint      x, y, z, xs, ys;
    logic [31:0] sum_q;
    sum_q = ang + 32'h40000000;
    flip = sum_q[31];
    t = flip ? ang + 32'h80000000 : ang;
    z = longint'($signed(t));
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TBL[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TBL[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint mul_q30(input longint travel, input longint f);
    logic [127:0] md, mf, p;
    longint m;
    md = {64'd0, (travel < 0) ? 64'(-travel) : 64'(travel)};
    mf = {64'd0, (f < 0) ? 64'(-f) : 64'(f)};
    p = md * mf;
    m = longint'(p[93:30]);
    return ((travel < 0) != (f < 0)) ? -m : m;
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  function automatic logic signed [15:0] round_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return 16'(r);
  endfunction

  // advance the pose by one wheel sample
  function automatic pose_t odometry_step(input wheel_sample_t smp);
    logic [127:0] n, mag, q;
    logic [31:0]  dt, dth;
    longint sum, diff, travel, c, s;
    pose_t res;
    dt = smp.stamp_us - odo_stamp;
    sum = longint'(smp.left_rpm) + longint'(smp.right_rpm);
    diff = longint'(smp.right_rpm) - longint'(smp.left_rpm);
    mag = (sum < 0) ? 128'(-sum) : 128'(sum);
    n = mag * 128'(radius_um) * 128'(dt) * 128'(ddo_pkg::PI_Q30);
    q = n / (128'd15360000000 << 30);
    travel = longint'(q[63:0]);
    if (sum < 0) travel = -travel;
    dth = '0;
    if (base_um != 0) begin
      mag = (diff < 0) ? 128'(-diff) : 128'(diff);
      n = (mag * 128'(radius_um) * 128'(dt)) << 24;
      q = n / (128'd60000000 * 128'(base_um));
      dth = q[31:0];
      if (diff < 0) dth = 32'd0 - dth;
    end
    cordic_sincos(odo_heading, c, s);
    odo_x = clamp_pos(odo_x + mul_q30(travel, c));
    odo_y = clamp_pos(odo_y + mul_q30(travel, s));
    odo_heading = odo_heading + dth;
    odo_stamp = smp.stamp_us;
    cordic_sincos(odo_heading >> 1, c, s);
    res.pos_x = odo_x[39:0];
    res.pos_y = odo_y[39:0];
    res.heading = odo_heading;
    res.qz = round_q15(s);
    res.qw = round_q15(c);
    return res;
  endfunction

  // idle control: quiet stretches turn off random gaps on both sides
  logic quiet;

  // driver: one transfer per accepted sample
  always @(posedge clk or negedge rst_n) begin
    wheel_sample_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
      left_rpm <= '0;
      right_rpm <= '0;
      stamp_us <= '0;
    end else begin
      if (push && !full) begin
        poses_expected.push_back(odometry_step(samples_pending.pop_front()));
        n_sent++;
      end
      if (samples_pending.size() > 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
        nxt = samples_pending[0];
        push <= 1'b1;
        left_rpm <= nxt.left_rpm;
        right_rpm <= nxt.right_rpm;
        stamp_us <= nxt.stamp_us;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: compare each result transfer with the oldest expected pose
  always @(posedge clk or negedge rst_n) begin
    pose_t e;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (poses_expected.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          e = poses_expected.pop_front();
          n_checked++;
          if (pos_x_o !== e.pos_x) begin
            $error("pos_x_um exp %0d got %0d", e.pos_x, pos_x_o); errors++;
          end
          if (pos_y_o !== e.pos_y) begin
            $error("pos_y_um exp %0d got %0d", e.pos_y, pos_y_o); errors++;
          end
          if (heading_o !== e.heading) begin
            $error("heading_angle exp %h got %h", e.heading, heading_o); errors++;
          end
          if (quat_z_o !== e.qz) begin
            $error("quat_z exp %0d got %0d", e.qz, quat_z_o); errors++;
          end
          if (quat_w_o !== e.qw) begin
            $error("quat_w exp %0d got %0d", e.qw, quat_w_o); errors++;
          end
        end
      end
      pop <= quiet || ($urandom_range(0, 99) >= 15);
    end
  end

  logic [31:0] gen_stamp;

  task automatic add_sample(input int l, input int r, input logic [31:0] st);
    wheel_sample_t smp;
    smp.left_rpm = 24'(l);
    smp.right_rpm = 24'(r);
    smp.stamp_us = st;
    samples_pending.push_back(smp);
    gen_stamp = st;
  endtask

  // wait until everything sent has come back and the back end has drained
  task automatic drain();
    while (samples_pending.size() > 0 || poses_expected.size() > 0 || push)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ddo_pkg::CFG_RADIUS) radius_um = val[19:0];
    else base_um = val[23:0];
  endtask

  task automatic random_run(input int count);
    int v;
    for (int i = 0; i < count; i++) begin
      v = $urandom_range(0, 99);
      if (v < 8)
        add_sample($urandom, $urandom, $urandom);
      else if (v < 12)
        add_sample($urandom, $urandom, gen_stamp + $urandom_range(0, 2000000));
      else
        add_sample(int'($urandom_range(0, 102400)) - 51200,
                   int'($urandom_range(0, 102400)) - 51200,
                   gen_stamp + $urandom_range(500, 50000));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = ddo_pkg::CFG_RADIUS; cfg_data = '0;
    quiet = 1'b0;
    radius_um = ddo_pkg::RADIUS_RESET;
    base_um = ddo_pkg::BASE_RESET;
    gen_stamp = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: first sample from stamp zero, extremes, backward stamp
    add_sample(0, 0, 32'd10000);
    add_sample(25600, 25600, 32'd20000);
    add_sample(-25600, 25600, 32'd30000);
    add_sample(8388607, -8388608, 32'd40000);
    add_sample(-8388608, 8388607, 32'd41000);
    add_sample(-8388608, -8388608, 32'd42000);
    add_sample(8388607, 8388607, 32'd43000);
    add_sample(12800, -12800, 32'd100);
    add_sample(1, -1, 32'hFFFFFFFF);
    add_sample(-1, 0, 32'hFFFFFFFF);
    drain();

    // saturate position with the largest wheel and a long step
    write_reg(ddo_pkg::CFG_RADIUS, 24'hFFFFFF);
    write_reg(ddo_pkg::CFG_BASE, 24'd1);
    add_sample(8388607, 8388607, 32'h7FFFFFFF);
    add_sample(8388607, 8388607, 32'hFFFFFFFE);
    add_sample(-8388608, -8388608, 32'h7FFFFFFF);
    add_sample(-8388608, 8388607, 32'h8FFFFFFF);
    drain();

    // zero radius, then zero base
    write_reg(ddo_pkg::CFG_RADIUS, 24'd0);
    add_sample(5000, 9000, gen_stamp + 32'd20000);
    add_sample(-8388608, 8388607, gen_stamp + 32'd20000);
    drain();
    write_reg(ddo_pkg::CFG_RADIUS, 24'd30000);
    write_reg(ddo_pkg::CFG_BASE, 24'd0);
    add_sample(10000, -30000, gen_stamp + 32'd20000);
    add_sample(25600, 0, gen_stamp + 32'd20000);
    drain();

    // random phases across several geometries
    write_reg(ddo_pkg::CFG_BASE, 24'd165000);
    random_run(300);
    drain();
    write_reg(ddo_pkg::CFG_RADIUS, 24'd1);
    write_reg(ddo_pkg::CFG_BASE, 24'hFFFFFF);
    random_run(200);
    drain();
    write_reg(ddo_pkg::CFG_RADIUS, 24'd1000000);
    write_reg(ddo_pkg::CFG_BASE, 24'd10000000);
    quiet = 1'b1;
    random_run(250);
    drain();
    quiet = 1'b0;
    write_reg(ddo_pkg::CFG_RADIUS, 24'($urandom));
    write_reg(ddo_pkg::CFG_BASE, 24'($urandom));
    random_run(250);
    drain();
    write_reg(ddo_pkg::CFG_RADIUS, 24'd50000);
    write_reg(ddo_pkg::CFG_BASE, 24'd300000);
    random_run(520);
    drain();

    $display("sent %0d wheel samples, checked %0d poses over a range of wheel geometries",
             n_sent, n_checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
